// ===== rtl/linear_probe_hash_table_defines.svh =====
// assertion macros for the linear probing hash table
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition holds in the same cycle
`define LPHT_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lpht: same-cycle check failed");
// condition holds in the following cycle
`define LPHT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lpht: next-cycle check failed");
`else
`define LPHT_ASSERT_SAME(name, clk, rst_n, pre, post)
`define LPHT_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/lpht_pkg.sv =====
// shared types and constants of the linear probing hash table
package lpht_pkg;

    localparam int TABLE_SIZE_DEF = 32;
    localparam int CMD_W          = 2;
    localparam int KEY_W          = 16;
    localparam int VAL_W          = 16;
    localparam int STAT_W         = 2;
    localparam int SLOT_W         = 5;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // slot states
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_GONE  = 2'd2;

    // result codes
    localparam logic [STAT_W-1:0] RES_OK      = 2'd0;
    localparam logic [STAT_W-1:0] RES_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] RES_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
        logic [SLOT_W-1:0] slot;
    } result_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_FIN
    } state_t;

endpackage

// ===== rtl/lpht_home.sv =====
// home slot unit: key modulo table size
module lpht_home
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] home
);

    localparam int IW   = $clog2(TABLE_SIZE);
    localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    generate
        if (POW2) begin : g_mask
            logic          done_reg;
            logic [IW-1:0] home_reg;

            // power of two: low key bits
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    home_reg <= key[IW-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_recip
            // quotient by reciprocal multiply, exact for every key of KEY_W bits
            localparam int SH    = KEY_W + IW;
            localparam int MUL_W = KEY_W + 1;
            localparam int PRD_W = KEY_W + MUL_W;
            localparam int QUO_W = PRD_W - SH;
            localparam longint unsigned MUL_L =
                ((longint'(1) << SH) + longint'(TABLE_SIZE) - 1) / longint'(TABLE_SIZE);
            localparam logic [MUL_W-1:0] MUL   = MUL_W'(MUL_L);
            localparam logic [KEY_W-1:0] T_KEY = KEY_W'(TABLE_SIZE);

            logic             stage_reg;
            logic             done_reg;
            logic [KEY_W-1:0] key_reg;
            logic [QUO_W-1:0] quo_reg;
            logic [IW-1:0]    home_reg;
            logic [PRD_W-1:0] prod;
            logic [KEY_W-1:0] back;
            logic [KEY_W-1:0] rem;

            // the quotient is registered, then key minus quotient times size is registered as the home slot
            assign prod = {{MUL_W{1'b0}}, key} * {{KEY_W{1'b0}}, MUL};
            assign back = {{(KEY_W-QUO_W){1'b0}}, quo_reg} * T_KEY;
            assign rem  = key_reg - back;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end else begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    key_reg <= key;
                    quo_reg <= prod[PRD_W-1:SH];
                end
                if (stage_reg) begin
                    home_reg <= rem[IW-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
    endgenerate

endmodule

// ===== rtl/lpht_mem.sv =====
// slot store: one write port, one registered read port
module lpht_mem
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output entry_t                        rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
    input  entry_t                        wr_data
);

    entry_t mem [TABLE_SIZE];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lpht_ctrl.sv =====
// probe sequencer: clearing pass, probe walk and write-back
module lpht_ctrl
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [CMD_W-1:0]              s_command,
    input  logic [KEY_W-1:0]              s_key,
    input  logic [VAL_W-1:0]              s_value,
    output logic                          res_valid,
    input  logic                          res_ready,
    output result_t                       res,
    output logic                          home_start,
    input  logic                          home_done,
    input  logic [$clog2(TABLE_SIZE)-1:0] home_idx,
    output logic                          mem_rd_en,
    output logic [$clog2(TABLE_SIZE)-1:0] mem_rd_addr,
    input  entry_t                        mem_rd_data,
    output logic                          mem_wr_en,
    output logic [$clog2(TABLE_SIZE)-1:0] mem_wr_addr,
    output entry_t                        mem_wr_data
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    result_t          res_reg, res_next;

    logic          s_fire;
    logic          cmd_ok;
    logic          is_ins;
    logic          hit_ins;
    logic          hit_key;
    logic          miss_empty;
    logic          last_probe;
    logic          finish;
    logic [IW-1:0] idx_inc;
    entry_t        rd;

    // probe decisions on the slot just read
    assign rd         = mem_rd_data;
    assign s_fire     = s_valid && s_ready;
    assign cmd_ok     = (s_command == CMD_INSERT) || (s_command == CMD_SEARCH) ||
                        (s_command == CMD_DELETE);
    assign is_ins     = (cmd_reg == CMD_INSERT);
    assign hit_ins    = is_ins && (rd.st != ST_USED);
    assign hit_key    = !is_ins && (rd.st == ST_USED) && (rd.key == key_reg);
    assign miss_empty = !is_ins && (rd.st == ST_EMPTY);
    assign last_probe = (cnt_reg == LAST);
    assign finish     = hit_ins || hit_key || miss_empty || last_probe;
    assign idx_inc    = (idx_reg == LAST) ? '0 : idx_reg + IW'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (idx_reg == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = cmd_ok ? S_HOME : S_FIN;
                end
            end
            S_HOME: begin
                if (home_done) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (finish) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready     = 1'b0;
        res_valid   = 1'b0;
        home_start  = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '{st: ST_EMPTY, key: '0, value: '0};
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        case (state_reg)
            S_CLEAR: begin
                mem_wr_en = 1'b1;
                idx_next  = idx_inc;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    cmd_next = s_command;
                    key_next = s_key;
                    val_next = s_value;
                    if (cmd_ok) begin
                        home_start = 1'b1;
                    end else begin
                        res_next = '{status: RES_MISSING, found_value: '0, slot: '0};
                    end
                end
            end
            S_HOME: begin
                if (home_done) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = home_idx;
                    idx_next    = home_idx;
                    cnt_next    = '0;
                end
            end
            S_PROBE: begin
                if (finish) begin
                    res_next = '{status: (is_ins ? RES_FULL : RES_MISSING),
                                 found_value: '0, slot: '0};
                    if (hit_ins) begin
                        res_next    = '{status: RES_OK, found_value: '0,
                                        slot: SLOT_W'(idx_reg)};
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{st: ST_USED, key: key_reg, value: val_reg};
                    end else if (hit_key) begin
                        res_next = '{status: RES_OK, found_value: rd.value,
                                     slot: SLOT_W'(idx_reg)};
                        // delete leaves a tombstone
                        if (cmd_reg == CMD_DELETE) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = '{st: ST_GONE, key: rd.key, value: rd.value};
                        end
                    end
                end else begin
                    idx_next    = idx_inc;
                    cnt_next    = cnt_reg + IW'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_inc;
                end
            end
            S_FIN: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // item registers
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Linear probing hash table: one item at a time, one probe per cycle.
// Each item passes the home slot unit, then its probes; without a power-of-two TABLE_SIZE
// the home slot unit adds a subtract step; probes run 1 to TABLE_SIZE, one slot store read each.
// The result is then registered in the controller and again in the output register.
// After reset a clearing pass writes every slot empty, with s_ready low meanwhile.
// Results sit in an output register, so the next item can be taken while one waits.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [VAL_W-1:0]  s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [VAL_W-1:0]  m_found_value,
    output logic [SLOT_W-1:0] m_slot
);

    localparam int IW = $clog2(TABLE_SIZE);

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          home_start;
    logic          home_done;
    logic [IW-1:0] home_idx;
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    entry_t        mem_rd_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;

    logic    m_valid_reg, m_valid_next;
    result_t out_reg;
    logic    out_fail;

    lpht_home #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_home (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (home_start),
        .key    (s_key),
        .done   (home_done),
        .home   (home_idx)
    );

    lpht_mem #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mem (
        .aclk   (aclk),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data)
    );

    lpht_ctrl #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_key      (s_key),
        .s_value    (s_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .home_start (home_start),
        .home_done  (home_done),
        .home_idx   (home_idx),
        .mem_rd_en  (mem_rd_en),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .mem_wr_en  (mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data)
    );

    // output register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_found_value = out_reg.found_value;
    assign m_slot        = out_reg.slot;

    // checks
    assign out_fail = m_valid && (m_status != RES_OK);

    `LPHT_ASSERT_SAME(a_idle_no_result, aclk, aresetn, s_ready, !res_valid)
    `LPHT_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    `LPHT_ASSERT_NEXT(a_result_loaded, aclk, aresetn, res_valid && res_ready, m_valid)
    `LPHT_ASSERT_SAME(a_fail_zero, aclk, aresetn, out_fail, (m_slot == '0) && (m_found_value == '0))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the linear probing hash table
module tb
    import lpht_pkg::*;
();

    localparam int TBL_N         = TABLE_SIZE_DEF;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int TAIL_CYCLES   = 3 + TBL_N + 8;
    localparam int LONG_HOLD_AT  = 200;
    localparam int LONG_HOLD_LEN = 400;

    // command code the block does not decode
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        MIX_CHURN,
        MIX_FILL,
        MIX_DRAIN
    } mix_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        int unsigned      gap;
    } table_op_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command     = CMD_INSERT;
    logic [KEY_W-1:0]  s_key         = '0;
    logic [VAL_W-1:0]  s_value       = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [VAL_W-1:0]  m_found_value;
    logic [SLOT_W-1:0] m_slot;

    // shadow copy of the slot store
    logic [1:0]        tbl_state [TBL_N];
    logic [KEY_W-1:0]  tbl_key   [TBL_N];
    logic [VAL_W-1:0]  tbl_val   [TBL_N];

    table_op_t         cmd_queue[$];
    result_t           pending_replies[$];
    logic [KEY_W-1:0]  live_keys[$];

    table_op_t         staged_op;
    table_op_t         live_op;
    bit                staged        = 1'b0;
    int unsigned       gap_left      = 0;
    int unsigned       clr_idx;
    bit                gaps_on       = 1'b1;

    int unsigned       hold_left     = 0;
    bit                long_hold_done = 1'b0;
    int unsigned       stall_roll;
    result_t           want;

    int unsigned       items_queued  = 0;
    int unsigned       results_seen  = 0;
    int unsigned       fail_count    = 0;
    int unsigned       cycle_count   = 0;

    linear_probe_hash_table u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_slot        (m_slot)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // apply one command to the shadow table and return the reply it gives
    function automatic result_t apply_table_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] val);
        result_t     res;
        int unsigned idx;
        int unsigned n;
        bit          stop;
        res.status      = RES_MISSING;
        res.found_value = '0;
        res.slot        = '0;
        idx  = key % TBL_N;
        n    = 0;
        stop = 1'b0;
        if (cmd == CMD_INSERT) begin
            // first empty or tombstoned slot of the walk
            res.status = RES_FULL;
            while (n < TBL_N && !stop) begin
                if (tbl_state[idx] != ST_USED) begin
                    tbl_state[idx] = ST_USED;
                    tbl_key[idx]   = key;
                    tbl_val[idx]   = val;
                    res.status     = RES_OK;
                    res.slot       = SLOT_W'(idx);
                    stop           = 1'b1;
                end else begin
                    idx = (idx + 1) % TBL_N;
                    n++;
                end
            end
        end else if (cmd == CMD_SEARCH || cmd == CMD_DELETE) begin
            // stop on a live match or an empty slot, skip tombstones
            while (n < TBL_N && !stop) begin
                if (tbl_state[idx] == ST_EMPTY) begin
                    stop = 1'b1;
                end else if (tbl_state[idx] == ST_USED && tbl_key[idx] == key) begin
                    res.status      = RES_OK;
                    res.found_value = tbl_val[idx];
                    res.slot        = SLOT_W'(idx);
                    if (cmd == CMD_DELETE) begin
                        tbl_state[idx] = ST_GONE;
                    end
                    stop = 1'b1;
                end else begin
                    idx = (idx + 1) % TBL_N;
                    n++;
                end
            end
        end
        return res;
    endfunction

    // keys: anywhere, crowded onto a few home slots, or at the extremes
    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        case ($urandom_range(0, 5))
            0, 1: k = KEY_W'($urandom);
            2, 3, 4: k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 7));
            default: k = ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: v = VAL_W'($urandom);
        endcase
        return v;
    endfunction

    // mostly a key that is live in the table, sometimes any key
    function automatic logic [KEY_W-1:0] target_key();
        if (live_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        end
        return rand_key();
    endfunction

    task automatic push_op(input logic [CMD_W-1:0] cmd,
                           input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
        table_op_t   op;
        int unsigned roll;
        int unsigned i;
        bit          gone;
        roll   = $urandom_range(0, 99);
        op.cmd = cmd;
        op.key = key;
        op.val = val;
        if (!gaps_on || roll < 65) begin
            op.gap = 0;
        end else if (roll < 95) begin
            op.gap = $urandom_range(1, 3);
        end else begin
            op.gap = $urandom_range(15, 60);
        end
        cmd_queue.push_back(op);
        items_queued++;
        // keep the list of live keys in step for picking targets
        if (cmd == CMD_INSERT && live_keys.size() < TBL_N) begin
            live_keys.push_back(key);
        end else if (cmd == CMD_DELETE) begin
            i    = 0;
            gone = 1'b0;
            while (i < live_keys.size() && !gone) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    gone = 1'b1;
                end else begin
                    i++;
                end
            end
        end
    endtask

    task automatic run_mix(input mix_t mix, input int unsigned count);
        int unsigned roll;
        int unsigned ins_cut;
        int unsigned srch_cut;
        int unsigned del_cut;
        case (mix)
            MIX_FILL: begin
                ins_cut = 70; srch_cut = 85; del_cut = 93;
            end
            MIX_DRAIN: begin
                ins_cut = 15; srch_cut = 45; del_cut = 95;
            end
            default: begin
                ins_cut = 38; srch_cut = 68; del_cut = 93;
            end
        endcase
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_cut) begin
                push_op(CMD_INSERT, rand_key(), rand_value());
            end else if (roll < srch_cut) begin
                push_op(CMD_SEARCH, target_key(), rand_value());
            end else if (roll < del_cut) begin
                push_op(CMD_DELETE, target_key(), rand_value());
            end else begin
                push_op(CMD_UNUSED, rand_key(), rand_value());
            end
        end
        // sender pauses until every reply of the batch is back
        wait (results_seen == items_queued);
    endtask

    // driver: predict on each input transfer, then offer the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            staged   = 1'b0;
            gap_left = 0;
            for (clr_idx = 0; clr_idx < TBL_N; clr_idx++) begin
                tbl_state[clr_idx] = ST_EMPTY;
                tbl_key[clr_idx]   = '0;
                tbl_val[clr_idx]   = '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                pending_replies.push_back(
                    apply_table_command(live_op.cmd, live_op.key, live_op.val));
            end
            if (!s_valid || s_ready) begin
                if (!staged && cmd_queue.size() != 0) begin
                    staged_op = cmd_queue.pop_front();
                    staged    = 1'b1;
                    gap_left  = staged_op.gap;
                end
                if (staged && gap_left == 0) begin
                    s_valid   <= 1'b1;
                    s_command <= staged_op.cmd;
                    s_key     <= staged_op.key;
                    s_value   <= staged_op.val;
                    live_op   = staged_op;
                    staged    = 1'b0;
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left != 0) begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // monitor: check each result transfer, then choose the next ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: result with none expected, status %0d value %0h slot %0d",
                             $time, m_status, m_found_value, m_slot);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_status);
                        fail_count++;
                    end
                    if (m_found_value !== want.found_value) begin
                        $display("%0t: found_value mismatch, expected %0h, actual %0h",
                                 $time, want.found_value, m_found_value);
                        fail_count++;
                    end
                    if (m_slot !== want.slot) begin
                        $display("%0t: slot mismatch, expected %0d, actual %0d",
                                 $time, want.slot, m_slot);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                // one long back-pressure stretch so the input side stalls
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_LEN - 1;
                m_ready        <= 1'b0;
            end else if ((results_seen / 100) % 4 == 2) begin
                m_ready <= 1'b1;
            end else begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready   <= 1'b0;
                    hold_left = (stall_roll < 96) ? $urandom_range(0, 3)
                                                  : $urandom_range(20, 60);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table
        push_op(CMD_SEARCH, 16'h0000, 16'h1234);
        push_op(CMD_DELETE, 16'hFFFF, 16'h0000);
        // extremes, collisions on home slot 0, wrap from the last slot
        push_op(CMD_INSERT, 16'h0000, 16'h0000);
        push_op(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        push_op(CMD_INSERT, 16'h0020, 16'hA5A5);
        push_op(CMD_INSERT, 16'h7FE0, 16'h5A5A);
        push_op(CMD_INSERT, 16'hFFDF, 16'h0F0F);
        push_op(CMD_SEARCH, 16'h0020, 16'hFFFF);
        // tombstone left by delete, then passed over and reused
        push_op(CMD_DELETE, 16'h0020, 16'h0000);
        push_op(CMD_SEARCH, 16'h7FE0, 16'h0000);
        push_op(CMD_SEARCH, 16'h0020, 16'h0000);
        push_op(CMD_INSERT, 16'h0040, 16'h8001);
        // undecoded command changes nothing
        push_op(CMD_UNUSED, 16'h0000, 16'hFFFF);
        push_op(CMD_DELETE, 16'h0000, 16'h0000);
        // duplicate key lands in the earlier free slot and shadows the first
        push_op(CMD_INSERT, 16'h0040, 16'h7FFE);
        push_op(CMD_SEARCH, 16'h0040, 16'h0000);
        push_op(CMD_SEARCH, 16'hFFDF, 16'h0000);
        wait (results_seen == items_queued);

        // random batches, filling to a full table and draining to tombstones
        run_mix(MIX_FILL, 60);
        run_mix(MIX_CHURN, 90);
        run_mix(MIX_DRAIN, 70);
        gaps_on = 1'b0;
        run_mix(MIX_CHURN, 80);
        gaps_on = 1'b1;
        run_mix(MIX_FILL, 70);
        run_mix(MIX_CHURN, 90);
        run_mix(MIX_DRAIN, 80);
        run_mix(MIX_FILL, 60);
        run_mix(MIX_CHURN, 100);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_replies.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_home.sv
rtl/lpht_mem.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
verif/tb.sv
